### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define AM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define AM_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define AM_ASSERT(label, prop, msg)
`define AM_NEVER(label, expr, msg)

`endif

`endif

### hw/rtl/accm_pkg.sv
// Types, codes and sizes for the accumulator machine execute block.
package accm_pkg;

  // Data memory size in bytes, split over four byte-wide lanes.
  localparam int DATA_BYTES = 1024;
  localparam int LANES      = 4;
  localparam int ROWS       = (DATA_BYTES + LANES - 1) / LANES;
  localparam int ROW_W      = $clog2(ROWS);

  localparam int OFFSET_W = 10;
  localparam int COUNT_W  = 3;
  localparam int SEG_W    = 16;
  localparam int WORD_W   = 32;
  // Wide enough for offset + size and for any memory size up to 64 KiB.
  localparam int FIT_W    = 17;

  localparam logic [SEG_W-1:0] DATA_SEG_RESET = 16'd512;

  localparam logic ACT_PRELOAD = 1'b0;
  localparam logic ACT_EXEC    = 1'b1;

  localparam logic [7:0] OP_LOAD  = 8'd1;
  localparam logic [7:0] OP_STORE = 8'd2;
  localparam logic [7:0] OP_MULT  = 8'd3;
  localparam logic [7:0] OP_ADD   = 8'd4;
  localparam logic [7:0] OP_END   = 8'd5;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_SEGMENT = 2'd1,
    ST_NOP     = 2'd2,
    ST_BEYOND  = 2'd3
  } status_t;

  typedef struct packed {
    logic                action;
    logic [7:0]          opcode;
    logic [SEG_W-1:0]    segment;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  byte_count;
    logic [WORD_W-1:0]   preload_value;
  } accm_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] acc_value;
    logic [WORD_W-1:0]        mem_value;
    status_t                  status;
  } accm_out_t;

endpackage

### hw/rtl/accm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module accm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when both ports hit the same address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/accumulator_machine_execute.sv
// Accumulator machine execute stage: top level with byte-lane data memory.
// Path: the input transaction is registered with its RAM read, then executes into the out reg.
// Throughput: one item per cycle unless the output stalls or memory is clearing; four byte-lane
// RAMs with a one-deep write bypass let each item read and write an unaligned 1-4 byte operand.
// Reset (rst, synchronous): accumulator 0, segment base 512, then a clearing pass over all
// ROWS (256) rows zeroes data memory; no input is taken until it ends.
`include "assert_macros.svh"

module accumulator_machine_execute (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  accm_pkg::accm_in_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output accm_pkg::accm_out_t   out_data
);
  import accm_pkg::*;

  logic [SEG_W-1:0]  seg_base;
  logic [WORD_W-1:0] acc;

  // Clearing pass
  logic             clearing;
  logic [ROW_W-1:0] clr_row;

  // Input decode
  logic [COUNT_W-1:0]  in_n;
  logic [OFFSET_W:0]   in_sum;
  logic                in_ok;
  logic [ROW_W-1:0]    rd_row [LANES];
  logic                in_take;

  // Execute stage
  logic               s1_valid;
  accm_in_t           s1_item;
  logic [COUNT_W-1:0] s1_n;
  logic               s1_ok;
  logic [ROW_W-1:0]   s1_rows [LANES];
  logic               s1_go;

  // Write bypass: last byte written in each lane
  logic [LANES-1:0] byp_en;
  logic [ROW_W-1:0] byp_row  [LANES];
  logic [7:0]       byp_data [LANES];

  logic [7:0]       ram_rdata  [LANES];
  logic [7:0]       lane_d     [LANES];
  logic [7:0]       lane_new   [LANES];
  logic [LANES-1:0] lane_we;
  logic [7:0]       lane_wdata [LANES];
  logic             ram_we     [LANES];
  logic [ROW_W-1:0] ram_waddr  [LANES];
  logic [7:0]       ram_wdata  [LANES];

  logic [WORD_W-1:0] operand;
  logic [WORD_W-1:0] mem_after;
  logic [WORD_W-1:0] acc_next;
  logic [WORD_W-1:0] wval;
  logic              wr;
  status_t           exec_status;

  // ---------------- input side ----------------
  always_comb begin
    logic [OFFSET_W-2:0] row_ext;
    if (in_data.byte_count == 3'd0) begin
      in_n = 3'd1;
    end else if (in_data.byte_count > 3'd4) begin
      in_n = 3'd4;
    end else begin
      in_n = in_data.byte_count;
    end
    in_sum = {1'b0, in_data.offset} + {{(OFFSET_W + 1 - COUNT_W){1'b0}}, in_n};
    in_ok  = FIT_W'(in_sum) <= FIT_W'(DATA_BYTES);
    // lanes below the start lane hold bytes from the next row
    for (int l = 0; l < LANES; l++) begin
      row_ext = {1'b0, in_data.offset[OFFSET_W-1:2]}
              + {{(OFFSET_W - 2){1'b0}}, (2'(l) < in_data.offset[1:0])};
      rd_row[l] = ROW_W'(row_ext);
    end
  end

  assign s1_go    = s1_valid && (!out_valid || !out_stall);
  assign in_stall = clearing || (s1_valid && !s1_go);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= in_data;
      s1_n    <= in_n;
      s1_ok   <= in_ok;
      s1_rows <= rd_row;
    end
  end

  // ---------------- execute ----------------
  always_comb begin
    logic [1:0] idx;
    logic [1:0] bi;
    logic [1:0] sh;
    sh = s1_item.offset[1:0];

    for (int l = 0; l < LANES; l++) begin
      lane_d[l] = (byp_en[l] && (byp_row[l] == s1_rows[l])) ? byp_data[l] : ram_rdata[l];
    end

    operand = '0;
    for (int i = 0; i < LANES; i++) begin
      idx = sh + 2'(i);
      if (3'(i) < s1_n) begin
        operand[8*i +: 8] = lane_d[idx];
      end
    end

    exec_status = ST_DONE;
    acc_next    = acc;
    wr          = 1'b0;
    wval        = s1_item.preload_value;
    if (s1_item.action == ACT_PRELOAD) begin
      if (s1_ok) begin
        wr = 1'b1;
      end else begin
        exec_status = ST_BEYOND;
      end
    end else if (s1_item.opcode < OP_LOAD || s1_item.opcode > OP_ADD) begin
      // end and unknown opcodes
      exec_status = ST_NOP;
    end else if (s1_item.segment != seg_base) begin
      exec_status = ST_SEGMENT;
    end else if (!s1_ok) begin
      exec_status = ST_BEYOND;
    end else begin
      unique case (s1_item.opcode)
        OP_LOAD:  acc_next = operand;
        OP_STORE: begin
          wr   = 1'b1;
          wval = acc;
        end
        OP_MULT:  acc_next = acc * operand;
        OP_ADD:   acc_next = acc + operand;
        default:  acc_next = acc;
      endcase
    end

    for (int l = 0; l < LANES; l++) begin
      bi            = 2'(l) - sh;
      lane_we[l]    = wr && ({1'b0, bi} < s1_n);
      lane_wdata[l] = wval[8*bi +: 8];
      lane_new[l]   = lane_we[l] ? lane_wdata[l] : lane_d[l];
    end

    mem_after = '0;
    if (s1_ok) begin
      for (int i = 0; i < LANES; i++) begin
        idx = sh + 2'(i);
        if (3'(i) < s1_n) begin
          mem_after[8*i +: 8] = lane_new[idx];
        end
      end
    end
  end

  // ---------------- data memory ----------------
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ram_we[l]    = clearing || (s1_go && lane_we[l]);
      ram_waddr[l] = clearing ? clr_row : s1_rows[l];
      ram_wdata[l] = clearing ? 8'd0 : lane_wdata[l];
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    accm_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[g]),
      .waddr (ram_waddr[g]),
      .wdata (ram_wdata[g]),
      .re    (in_take),
      .raddr (rd_row[g]),
      .rdata (ram_rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == ROW_W'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_en <= '0;
    end else if (s1_go) begin
      for (int l = 0; l < LANES; l++) begin
        if (lane_we[l]) begin
          byp_en[l] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      for (int l = 0; l < LANES; l++) begin
        if (lane_we[l]) begin
          byp_row[l]  <= s1_rows[l];
          byp_data[l] <= lane_wdata[l];
        end
      end
    end
  end

  // ---------------- architectural state and output ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_base <= DATA_SEG_RESET;
    end else if (cfg_wr_en) begin
      seg_base <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s1_go) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data.acc_value <= $signed(acc_next);
      out_data.mem_value <= mem_after;
      out_data.status    <= exec_status;
    end
  end

  // ---------------- checks ----------------
  `AM_NEVER(a_no_exec_clearing, clearing && s1_valid, "item in execute during clearing")
  `AM_NEVER(a_write_in_range, (|lane_we) && !s1_ok, "memory write past end of memory")
  `AM_ASSERT(a_acc_hold, (s1_go && exec_status != ST_DONE) |=> acc == $past(acc), "acc changed")
  `AM_ASSERT(a_clear_len, $fell(clearing) |-> $past(clr_row) == ROW_W'(ROWS-1), "clear too short")

endmodule
